@@ design/gbn_pkg.sv @@
// Shared constants, codes and control structs for the go-back-n sender window.
// Used by gbn_ctrl, gbn_datapath and go_back_n_sender_window; no dependencies.
`default_nettype none

package gbn_pkg;

   // window size and sequence space
   localparam int WINDOW  = 3;
   localparam int SEQ_MOD = WINDOW + 1;
   localparam int SEQ_W   = 2;
   localparam int CNT_W   = 2;
   localparam int DATA_W  = 32;

   // request kinds
   localparam logic [1:0] KIND_NEW     = 2'd0;
   localparam logic [1:0] KIND_ACK     = 2'd1;
   localparam logic [1:0] KIND_TIMEOUT = 2'd2;

   // response status codes
   localparam logic [2:0] STAT_SENT     = 3'd0;
   localparam logic [2:0] STAT_FULL     = 3'd1;
   localparam logic [2:0] STAT_ACK_OK   = 3'd2;
   localparam logic [2:0] STAT_ACK_IGN  = 3'd3;
   localparam logic [2:0] STAT_NOTHING  = 3'd4;

   // datapath operations
   localparam logic [2:0] OP_SEND    = 3'd0;
   localparam logic [2:0] OP_REJECT  = 3'd1;
   localparam logic [2:0] OP_ACK_OK  = 3'd2;
   localparam logic [2:0] OP_ACK_IGN = 3'd3;
   localparam logic [2:0] OP_EMPTY   = 3'd4;
   localparam logic [2:0] OP_REPLAY  = 3'd5;

   typedef struct packed {
      logic             load;
      logic [2:0]       op;
      logic [SEQ_W-1:0] idx;
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic             out_free;
      logic             full;
      logic             empty;
      logic             ack_match;
      logic [CNT_W-1:0] count;
   } stat_type;

endpackage

`default_nettype wire

@@ design/go_back_n_sender_window.sv @@
// Go-back-n ARQ sender window, top level.
// Request channel (req_*): one word per event: kind 0 new packet with req_payload,
//   kind 1 ack carrying req_ack_num, kind 2 timeout; kind 3 is dropped with no result.
// Response channel (rsp_*): status, frame sequence number, frame data, the number of
//   unacknowledged frames after the result, and last on the final word of a request.
// A word moves on either channel at a clock edge where valid is high and stall is low.
// The result is registered and appears in the cycle after the request is taken.
// New packets and acks each give one result word. A timeout with n frames
//   outstanding (up to 3) replays them oldest first, one word per cycle from the
//   payload buffer while the receiver does not stall; the replay sequencer holds
//   req_stall high meanwhile.
// A response stalled by the receiver holds in the output register; a new request is
//   taken in the same cycle the held word is taken.
// Synchronous active-high reset empties the window (all pointers and the count to
//   zero) and drops any pending response; the buffer itself is not cleared.
// Depends on gbn_pkg, gbn_ctrl and gbn_datapath.
`default_nettype none

module go_back_n_sender_window
   import gbn_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_kind,
   input  wire logic [DATA_W-1:0] req_payload,
   input  wire logic [SEQ_W-1:0]  req_ack_num,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [2:0]             rsp_status,
   output logic [SEQ_W-1:0]       rsp_frame_seq,
   output logic [DATA_W-1:0]      rsp_frame_payload,
   output logic [CNT_W-1:0]       rsp_outstanding,
   output logic                   rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .stat      (stat),
      .cmd       (cmd)
   );

   gbn_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_payload       (req_payload),
      .req_ack_num       (req_ack_num),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_frame_seq     (rsp_frame_seq),
      .rsp_frame_payload (rsp_frame_payload),
      .rsp_outstanding   (rsp_outstanding),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

@@ design/gbn_ctrl.sv @@
// Controller for the go-back-n sender: request intake and timeout replay sequencing.
// Depends on gbn_pkg; drives commands into gbn_datapath.
`default_nettype none

module gbn_ctrl
   import gbn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire stat_type    stat,
   output cmd_type          cmd
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_REPLAY = 1'b1;

   logic             state_ff, state_in;
   logic [SEQ_W-1:0] idx_ff, idx_in;
   logic             accept;
   logic             rep_last;

   // stall while replaying or while the output word is blocked
   assign req_stall = (state_ff != ST_IDLE) || !stat.out_free;
   assign accept    = req_valid && !req_stall;
   assign rep_last  = ({1'b0, idx_ff} + 1'b1) == {1'b0, stat.count};

   // decode the next command
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_NEW: begin
                     cmd.load = 1'b1;
                     cmd.op   = stat.full ? OP_REJECT : OP_SEND;
                     cmd.last = 1'b1;
                  end
                  KIND_ACK: begin
                     cmd.load = 1'b1;
                     cmd.op   = stat.ack_match ? OP_ACK_OK : OP_ACK_IGN;
                     cmd.last = 1'b1;
                  end
                  KIND_TIMEOUT: begin
                     cmd.load = 1'b1;
                     if (stat.empty) begin
                        cmd.op   = OP_EMPTY;
                        cmd.last = 1'b1;
                     end else begin
                        cmd.op   = OP_REPLAY;
                        cmd.idx  = '0;
                        cmd.last = (stat.count == CNT_W'(1));
                        if (stat.count != CNT_W'(1)) begin
                           state_in = ST_REPLAY;
                           idx_in   = SEQ_W'(1);
                        end
                     end
                  end
                  default: begin
                     // undefined kind: drop without a result
                  end
               endcase
            end
         end
         ST_REPLAY: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               cmd.op   = OP_REPLAY;
               cmd.idx  = idx_ff;
               cmd.last = rep_last;
               if (rep_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and replay index
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

@@ design/gbn_datapath.sv @@
// Datapath for the go-back-n sender: window pointers, payload buffer, response word.
// Depends on gbn_pkg; executes commands from gbn_ctrl.
`default_nettype none

module gbn_datapath
   import gbn_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [DATA_W-1:0] req_payload,
   input  wire logic [SEQ_W-1:0]  req_ack_num,
   input  wire cmd_type           cmd,
   output stat_type               stat,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [2:0]             rsp_status,
   output logic [SEQ_W-1:0]       rsp_frame_seq,
   output logic [DATA_W-1:0]      rsp_frame_payload,
   output logic [CNT_W-1:0]       rsp_outstanding,
   output logic                   rsp_last
);

   localparam logic [SEQ_W:0] SEQ_MOD_X = (SEQ_W + 1)'(SEQ_MOD);

   logic [DATA_W-1:0] store_mem [SEQ_MOD];

   logic [SEQ_W-1:0]  oldest_ff, oldest_in;
   logic [SEQ_W-1:0]  next_ff, next_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              valid_ff, valid_in;
   logic [2:0]        status_ff, status_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [DATA_W-1:0] data_ff;
   logic [CNT_W-1:0]  outst_ff, outst_in;
   logic              last_ff;
   logic              out_free;
   logic [SEQ_W:0]    rep_sum;
   logic [SEQ_W-1:0]  rep_addr;
   logic              do_send;
   logic              do_ack;

   // report window status
   assign out_free       = !valid_ff || !rsp_stall;
   assign stat.out_free  = out_free;
   assign stat.full      = count_ff >= CNT_W'(WINDOW);
   assign stat.empty     = count_ff == '0;
   assign stat.ack_match = (count_ff != '0) && (req_ack_num == oldest_ff);
   assign stat.count     = count_ff;

   assign do_send = cmd.load && (cmd.op == OP_SEND);
   assign do_ack  = cmd.load && (cmd.op == OP_ACK_OK);

   // replay address: oldest plus index, wrapped into the sequence space
   assign rep_sum  = {1'b0, oldest_ff} + {1'b0, cmd.idx};
   assign rep_addr = (rep_sum >= SEQ_MOD_X) ? SEQ_W'(rep_sum - SEQ_MOD_X) : rep_sum[SEQ_W-1:0];

   // advance window pointers
   always_comb begin
      oldest_in = oldest_ff;
      next_in   = next_ff;
      count_in  = count_ff;
      if (do_send) begin
         next_in  = (next_ff == SEQ_W'(SEQ_MOD - 1)) ? '0 : next_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (do_ack) begin
         oldest_in = (oldest_ff == SEQ_W'(SEQ_MOD - 1)) ? '0 : oldest_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   // build the next response word
   always_comb begin
      valid_in  = valid_ff;
      status_in = status_ff;
      seq_in    = seq_ff;
      outst_in  = outst_ff;
      if (out_free) begin
         valid_in = cmd.load;
      end
      if (cmd.load) begin
         seq_in   = '0;
         outst_in = count_ff;
         case (cmd.op)
            OP_SEND: begin
               status_in = STAT_SENT;
               seq_in    = next_ff;
               outst_in  = count_ff + 1'b1;
            end
            OP_REJECT:  status_in = STAT_FULL;
            OP_ACK_OK: begin
               status_in = STAT_ACK_OK;
               outst_in  = count_ff - 1'b1;
            end
            OP_ACK_IGN: status_in = STAT_ACK_IGN;
            OP_EMPTY:   status_in = STAT_NOTHING;
            OP_REPLAY: begin
               status_in = STAT_SENT;
               seq_in    = rep_addr;
            end
            default:    status_in = STAT_NOTHING;
         endcase
      end
   end

   // hold control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         next_ff   <= '0;
         count_ff  <= '0;
         valid_ff  <= 1'b0;
      end else begin
         oldest_ff <= oldest_in;
         next_ff   <= next_in;
         count_ff  <= count_in;
         valid_ff  <= valid_in;
      end
   end

   // hold response payload; replay data is read straight into the output word
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      seq_ff    <= seq_in;
      outst_ff  <= outst_in;
      if (cmd.load) begin
         last_ff <= cmd.last;
         if (cmd.op == OP_SEND) begin
            data_ff <= req_payload;
         end else if (cmd.op == OP_REPLAY) begin
            data_ff <= store_mem[rep_addr];
         end else begin
            data_ff <= '0;
         end
      end
   end

   // write new packets into the buffer
   always_ff @(posedge clock) begin
      if (do_send) begin
         store_mem[next_ff] <= req_payload;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_frame_seq     = seq_ff;
   assign rsp_frame_payload = data_ff;
   assign rsp_outstanding   = outst_ff;
   assign rsp_last          = last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW))
      else $error("outstanding count exceeds window");

   a_send_not_full: assert property (@(posedge clock) disable iff (reset)
      do_send |-> count_ff < CNT_W'(WINDOW))
      else $error("frame sent into a full window");

   a_ack_nonempty: assert property (@(posedge clock) disable iff (reset)
      do_ack |=> count_ff == $past(count_ff) - 1'b1)
      else $error("accepted ack did not retire one frame");

   a_replay_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && cmd.op == OP_REPLAY) |-> (count_ff != '0 && cmd.idx < count_ff))
      else $error("replay index outside outstanding frames");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> out_free)
      else $error("response word overwritten while stalled");
`endif

endmodule

`default_nettype wire
